### hdl/lws_pkg.sv
// Shared types and constants for the log window store.
`timescale 1ns / 1ps

package lws_pkg;

   // Ring depth; slot is the low bits of the log index, so this is a power of two.
   localparam int LOG_DEPTH = 1024;
   localparam int SLOT_W = $clog2(LOG_DEPTH);
   localparam logic [63:0] DEPTH_WIDE = 64'(LOG_DEPTH);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam int INDEX_W = 63;
   localparam int TERM_W = 63;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      ACT_LOOKUP   = 3'd0,
      ACT_APPEND   = 3'd1,
      ACT_PREFIX   = 3'd2,
      ACT_SUFFIX   = 3'd3,
      ACT_RESTART  = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_RANGE      = 3'd1,
      ST_APPEND_IDX = 3'd2,
      ST_BAD_RESET  = 3'd3,
      ST_FULL       = 3'd4
   } status_type;

   // One classified action, front to back.
   typedef struct packed {
      status_type           status;
      logic                 lookup_hit;
      logic                 write_en;
      logic [SLOT_W-1:0]    slot;
      logic [TERM_W-1:0]    term;
      logic [DATA_W-1:0]    data;
      logic [INDEX_W-1:0]   first;
      logic [INDEX_W-1:0]   last;
   } cmd_type;

endpackage

### hdl/lws_ram.sv
// Generic RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module lws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lws_front.sv
// Front part: holds the window bounds, classifies each action, emits a command.
`timescale 1ns / 1ps

module lws_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_action,
   input  logic [lws_pkg::INDEX_W-1:0]  req_log_index,
   input  logic [lws_pkg::TERM_W-1:0]   req_entry_term,
   input  logic [lws_pkg::DATA_W-1:0]   req_entry_data,
   input  logic                         queue_full,
   output logic                         queue_push,
   output lws_pkg::cmd_type             queue_cmd
);

   logic [63:0]                  first_ff, first_in;
   logic [lws_pkg::INDEX_W-1:0]  last_ff, last_in;
   logic [63:0]                  idx_ext;
   logic [63:0]                  last_ext;
   logic [63:0]                  held_count;
   lws_pkg::status_type          status;
   logic                         hit;
   logic                         wr;

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   assign idx_ext    = {1'b0, req_log_index};
   assign last_ext   = {1'b0, last_ff};
   assign held_count = last_ext + 64'd1 - first_ff;

   always_comb begin
      first_in = first_ff;
      last_in  = last_ff;
      status   = lws_pkg::ST_OK;
      hit      = 1'b0;
      wr       = 1'b0;
      case (lws_pkg::action_type'(req_action))
         lws_pkg::ACT_LOOKUP: begin
            if (idx_ext < first_ff || idx_ext > last_ext) begin
               status = lws_pkg::ST_RANGE;
            end else begin
               hit = 1'b1;
            end
         end
         lws_pkg::ACT_APPEND: begin
            if (idx_ext != last_ext + 64'd1) begin
               status = lws_pkg::ST_APPEND_IDX;
            end else if (held_count >= lws_pkg::DEPTH_WIDE) begin
               status = lws_pkg::ST_FULL;
            end else begin
               wr      = 1'b1;
               last_in = req_log_index;
            end
         end
         lws_pkg::ACT_PREFIX: begin
            if (idx_ext >= first_ff) begin
               first_in = idx_ext;
               if (idx_ext > last_ext) begin
                  last_in = req_log_index - 63'd1;
               end
            end
         end
         lws_pkg::ACT_SUFFIX: begin
            if (idx_ext <= last_ext) begin
               last_in = req_log_index;
               if (first_ff > idx_ext) begin
                  first_in = idx_ext + 64'd1;
               end
            end
         end
         lws_pkg::ACT_RESTART: begin
            if (req_log_index == '0) begin
               status = lws_pkg::ST_BAD_RESET;
            end else begin
               first_in = idx_ext;
               last_in  = req_log_index - 63'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      queue_cmd.status     = status;
      queue_cmd.lookup_hit = hit;
      queue_cmd.write_en   = wr;
      queue_cmd.slot       = req_log_index[lws_pkg::SLOT_W-1:0];
      queue_cmd.term       = req_entry_term;
      queue_cmd.data       = req_entry_data;
      queue_cmd.first      = first_in[lws_pkg::INDEX_W-1:0];
      queue_cmd.last       = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 64'd1;
         last_ff  <= '0;
      end else if (queue_push) begin
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

endmodule

### hdl/lws_queue.sv
// Small command queue between the front and back parts.
`timescale 1ns / 1ps

module lws_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lws_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output lws_pkg::cmd_type  head_cmd
);

   lws_pkg::cmd_type             entries_ff [lws_pkg::QUEUE_DEPTH];
   logic [lws_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [lws_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [lws_pkg::QPTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (lws_pkg::QPTR_W+1)'(lws_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/lws_back.sv
// Back part: slot write or read and the result register.
`timescale 1ns / 1ps

module lws_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         queue_empty,
   input  lws_pkg::cmd_type             queue_cmd,
   output logic                         queue_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [lws_pkg::TERM_W-1:0]   rsp_found_term,
   output logic [lws_pkg::DATA_W-1:0]   rsp_found_data,
   output logic [lws_pkg::INDEX_W-1:0]  rsp_first_index,
   output logic [lws_pkg::INDEX_W-1:0]  rsp_last_index
);

   logic                          rsp_valid_ff, rsp_valid_in;
   lws_pkg::status_type           status_ff;
   logic                          hit_ff;
   logic [lws_pkg::INDEX_W-1:0]   first_ff;
   logic [lws_pkg::INDEX_W-1:0]   last_ff;
   logic [lws_pkg::TERM_W-1:0]    term_rd;
   logic [lws_pkg::DATA_W-1:0]    data_rd;
   logic                          slot_wr;
   logic                          slot_rd;

   assign queue_pop = !queue_empty && (!rsp_valid_ff || !rsp_stall);
   assign slot_wr   = queue_pop && queue_cmd.write_en;
   assign slot_rd   = queue_pop && queue_cmd.lookup_hit;

   lws_ram #(.WIDTH(lws_pkg::TERM_W), .DEPTH(lws_pkg::LOG_DEPTH)) u_term_ram (
      .clock   (clock),
      .wr_en   (slot_wr),
      .wr_addr (queue_cmd.slot),
      .wr_data (queue_cmd.term),
      .rd_en   (slot_rd),
      .rd_addr (queue_cmd.slot),
      .rd_data (term_rd)
   );

   lws_ram #(.WIDTH(lws_pkg::DATA_W), .DEPTH(lws_pkg::LOG_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (slot_wr),
      .wr_addr (queue_cmd.slot),
      .wr_data (queue_cmd.data),
      .rd_en   (slot_rd),
      .rd_addr (queue_cmd.slot),
      .rd_data (data_rd)
   );

   always_comb begin
      if (queue_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         status_ff <= queue_cmd.status;
         hit_ff    <= queue_cmd.lookup_hit;
         first_ff  <= queue_cmd.first;
         last_ff   <= queue_cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_term  = hit_ff ? term_rd : '0;
   assign rsp_found_data  = hit_ff ? data_rd : '0;
   assign rsp_first_index = first_ff;
   assign rsp_last_index  = last_ff;

endmodule

### hdl/raft_log_window_store.sv
// Sustains one action per cycle unless req_stall or rsp_stall holds it; a result passes
// through a command queue entry, then the registered slot access and result registers.
// The front part checks the window bounds and updates them at once, so a
// following action sees the new window; the back part performs the single slot write
// (append) or read (lookup) per cycle in order, so a lookup always sees earlier
// appends. The four-entry queue absorbs result stalls; req_stall rises when it fills.
// Slots are not cleared after reset; only indices inside the window are ever read.
`timescale 1ns / 1ps

module raft_log_window_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_action,
   input  logic [lws_pkg::INDEX_W-1:0]  req_log_index,
   input  logic [lws_pkg::TERM_W-1:0]   req_entry_term,
   input  logic [lws_pkg::DATA_W-1:0]   req_entry_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [lws_pkg::TERM_W-1:0]   rsp_found_term,
   output logic [lws_pkg::DATA_W-1:0]   rsp_found_data,
   output logic [lws_pkg::INDEX_W-1:0]  rsp_first_index,
   output logic [lws_pkg::INDEX_W-1:0]  rsp_last_index
);

   logic              queue_full;
   logic              queue_push;
   logic              queue_empty;
   logic              queue_pop;
   lws_pkg::cmd_type  push_cmd;
   lws_pkg::cmd_type  head_cmd;

   lws_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_log_index  (req_log_index),
      .req_entry_term (req_entry_term),
      .req_entry_data (req_entry_data),
      .queue_full     (queue_full),
      .queue_push     (queue_push),
      .queue_cmd      (push_cmd)
   );

   lws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   lws_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .queue_cmd       (head_cmd),
      .queue_pop       (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_term  (rsp_found_term),
      .rsp_found_data  (rsp_found_data),
      .rsp_first_index (rsp_first_index),
      .rsp_last_index  (rsp_last_index)
   );

endmodule

### hdl/lws_check.sv
// Port-level checks for the log window store, bound to the top level.
`timescale 1ns / 1ps

module lws_check (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [2:0]                   rsp_status,
   input  logic [lws_pkg::TERM_W-1:0]   rsp_found_term,
   input  logic [lws_pkg::DATA_W-1:0]   rsp_found_data,
   input  logic [lws_pkg::INDEX_W-1:0]  rsp_first_index,
   input  logic [lws_pkg::INDEX_W-1:0]  rsp_last_index
);

   logic [lws_pkg::INDEX_W-1:0] held;

   assign held = rsp_last_index + 63'd1 - rsp_first_index;

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_window_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> held <= 63'(lws_pkg::LOG_DEPTH))
      else $error("window holds more entries than slots");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lws_pkg::ST_OK |-> rsp_found_term == '0 && rsp_found_data == '0)
      else $error("entry reported with error status");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind raft_log_window_store lws_check u_check (.*);
